### hdl/cclrn_pkg.sv
`default_nettype none
package cclrn_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_BIAS_K      = 2'd1;
  localparam logic [1:0] REG_ALPHA       = 2'd2;
  localparam logic [1:0] REG_BETA        = 2'd3;

  // Reset values of the registers
  localparam logic [3:0]  RST_WINDOW_SIZE = 4'd5;
  localparam logic [15:0] RST_BIAS_K      = 16'd256;
  localparam logic [31:0] RST_ALPHA       = 32'd86;
  localparam logic [15:0] RST_BETA        = 16'd12288;

  // Depth of the job queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Fraction bits of log2 and of the exponent
  localparam int FRAC_BITS = 24;

  typedef struct packed {
    logic [3:0]  window_size;
    logic [15:0] bias_k;
    logic [31:0] alpha_norm;
    logic [15:0] beta_exponent;
  } cclrn_cfg_t;

  // Factors 2^(2^-i), i = 1..FRAC_BITS, Q2.30
  typedef logic [FRAC_BITS-1:0][31:0] fact_tab_t;

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bv;
    n    = n_in;
    root = '0;
    bv   = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (n >= root + bv) begin
        n    = n - (root + bv);
        root = (root >> 1) + bv;
      end else begin
        root = root >> 1;
      end
      bv = bv >> 2;
    end
    return root;
  endfunction

  // Chain of square roots starting at 2.0
  function automatic fact_tab_t make_factors();
    fact_tab_t   t;
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int i = 0; i < FRAC_BITS; i++) begin
      c    = isqrt64(c << 30);
      t[i] = c[31:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

### hdl/cross_channel_lrn_forward.sv
`default_nettype none
// Channel | Direction | Handshake          | Contents
// in_     | input     | in_tvalid/tready   | tdata: sample; tlast: last_channel
// out_    | output    | out_tvalid/tready  | tdata: normalized; tlast: last
// cfg_    | input     | cfg_we             | cfg_index selects register, cfg_data value
//
// The front end takes one word per cycle while the job queue has room and no flush runs;
// the flush after a last channel shifts in zeros, queues pending results, then clears.
// Each result passes the back end in steps: take the job, scale (low and high products),
// leading-one search, one log squaring per fraction bit, exponent, one power step per
// fraction bit, magnitude, hand-off; a zero scale or sample goes from scale to hand-off.
// Reset (rst_n low, synchronous) empties the window and queue and loads register defaults.
// Output stall holds the back end in its last step; the front runs until the queue is full.
module cross_channel_lrn_forward
  import cclrn_pkg::*;
#(
  parameter int MAX_WINDOW = 15,
  parameter int DATA_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((DATA_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [((DATA_BITS+7)/8)*8-1:0]         out_tdata,  // normalized
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  localparam int TW    = ((DATA_BITS + 7) / 8) * 8;
  localparam int SUM_W = 2 * DATA_BITS + $clog2(MAX_WINDOW + 1);
  localparam int JOB_W = DATA_BITS + SUM_W + 1;

  cclrn_cfg_t           cfg_r;
  logic                 clr;
  logic                 job_push, q_full, q_empty, q_pop;
  logic [JOB_W-1:0]     job_data, q_data;
  logic [DATA_BITS-1:0] res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size   <= RST_WINDOW_SIZE;
      cfg_r.bias_k        <= RST_BIAS_K;
      cfg_r.alpha_norm    <= RST_ALPHA;
      cfg_r.beta_exponent <= RST_BETA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE: cfg_r.window_size   <= cfg_data[3:0];
        REG_BIAS_K:      cfg_r.bias_k        <= cfg_data[15:0];
        REG_ALPHA:       cfg_r.alpha_norm    <= cfg_data;
        REG_BETA:        cfg_r.beta_exponent <= cfg_data[15:0];
        default:         ;
      endcase
    end
  end

  assign clr = cfg_we && (cfg_index == REG_WINDOW_SIZE);

  cclrn_front #(
    .MAX_WINDOW(MAX_WINDOW),
    .DATA_BITS (DATA_BITS),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .window_size(cfg_r.window_size),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[DATA_BITS-1:0]),
    .in_last    (in_tlast),
    .job_push   (job_push),
    .job_data   (job_data),
    .q_full     (q_full)
  );

  cclrn_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_data),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_data (q_data)
  );

  cclrn_back #(
    .DATA_BITS(DATA_BITS),
    .SUM_W    (SUM_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (res),
    .out_last (out_tlast)
  );

  assign out_tdata = TW'(res);

endmodule
`default_nettype wire

### hdl/cclrn_queue.sv
`default_nettype none
module cclrn_queue
  import cclrn_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [NW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == NW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/cclrn_front.sv
`default_nettype none
module cclrn_front
  import cclrn_pkg::*;
#(
  parameter int MAX_WINDOW = 15,
  parameter int DATA_BITS  = 16,
  parameter int SUM_W      = 36
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clr,
  input  wire logic [3:0]                 window_size,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [DATA_BITS-1:0]       in_sample,
  input  wire logic                       in_last,
  output logic                            job_push,
  output logic [DATA_BITS+SUM_W:0]        job_data,
  input  wire logic                       q_full
);

  localparam int WIN_CAP = ((MAX_WINDOW - 1) | 1);
  localparam int PEND    = (WIN_CAP - 1) / 2 + 1;
  localparam int CW      = $clog2(PEND + 1);
  localparam int PIDX    = (PEND > 1) ? $clog2(PEND) : 1;
  localparam int WIDX    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SQ_W    = 2 * DATA_BITS;

  typedef enum logic {F_RUN, F_FLUSH} fstate_t;

  fstate_t              state_r, state_nxt;
  logic [SQ_W-1:0]      win_r [MAX_WINDOW];
  logic [SQ_W-1:0]      win_nxt [MAX_WINDOW];
  logic [DATA_BITS-1:0] pend_r [PEND];
  logic [DATA_BITS-1:0] pend_nxt [PEND];
  logic [DATA_BITS-1:0] app [PEND];
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CW-1:0]        pcnt_r, pcnt_nxt, span_r, span_nxt, cnt1, h;
  logic [3:0]           w_raw, w_eff;
  logic [SQ_W-1:0]      tail, sq, sq_in;
  logic [DATA_BITS-1:0] mag, job_sample;
  logic                 job_last, do_shift, do_clear, accept;

  // effective window: odd, capped
  assign w_raw = window_size | 4'd1;
  assign w_eff = (int'(w_raw) > WIN_CAP) ? 4'(WIN_CAP) : w_raw;
  assign h     = CW'(w_eff >> 1);
  assign tail  = win_r[WIDX'(w_eff - 4'd1)];

  assign mag = in_sample[DATA_BITS-1] ? -in_sample : in_sample;
  assign sq  = SQ_W'(mag) * SQ_W'(mag);

  assign in_ready = (state_r == F_RUN) && !q_full;
  assign accept   = in_valid && in_ready;
  assign job_data = {job_last, sum_nxt, job_sample};

  // window step, pending store and flush sequencing
  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    pcnt_nxt   = pcnt_r;
    span_nxt   = span_r;
    win_nxt    = win_r;
    pend_nxt   = pend_r;
    app        = pend_r;
    cnt1       = pcnt_r;
    job_push   = 1'b0;
    job_sample = pend_r[0];
    job_last   = 1'b0;
    do_shift   = 1'b0;
    do_clear   = 1'b0;
    sq_in      = '0;
    unique case (state_r)
      F_RUN: begin
        if (accept) begin
          do_shift = 1'b1;
          sq_in    = sq;
          if (pcnt_r < CW'(PEND)) begin
            app[PIDX'(pcnt_r)] = in_sample;
            cnt1 = CW'(pcnt_r + 1'b1);
          end
          pend_nxt = app;
          pcnt_nxt = cnt1;
          if (cnt1 > h) begin
            job_push   = 1'b1;
            job_sample = app[0];
            job_last   = in_last && (cnt1 == CW'(1));
            for (int i = 0; i < PEND - 1; i++) begin
              pend_nxt[i] = app[i+1];
            end
            pend_nxt[PEND-1] = '0;
            pcnt_nxt = cnt1 - 1'b1;
          end
          if (in_last) begin
            state_nxt = F_FLUSH;
            span_nxt  = pcnt_nxt;
          end
        end
      end
      F_FLUSH: begin
        priority if (pcnt_r == '0) begin
          do_clear  = 1'b1;
          state_nxt = F_RUN;
        end else if (span_r <= h) begin
          do_shift = 1'b1;
          span_nxt = span_r + 1'b1;
        end else if (!q_full) begin
          job_push   = 1'b1;
          job_sample = pend_r[0];
          job_last   = (pcnt_r == CW'(1));
          for (int i = 0; i < PEND - 1; i++) begin
            pend_nxt[i] = pend_r[i+1];
          end
          pend_nxt[PEND-1] = '0;
          pcnt_nxt = pcnt_r - 1'b1;
          span_nxt = span_r - 1'b1;
        end
      end
      default: state_nxt = F_RUN;
    endcase
    // running sum: square in, tail out
    if (do_shift) begin
      sum_nxt    = sum_r + SUM_W'(sq_in) - SUM_W'(tail);
      win_nxt[0] = sq_in;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        win_nxt[i] = win_r[i-1];
      end
    end
    if (do_clear || clr) begin
      sum_nxt  = '0;
      pcnt_nxt = '0;
      span_nxt = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_nxt[i] = '0;
      end
      for (int i = 0; i < PEND; i++) begin
        pend_nxt[i] = '0;
      end
    end
    if (clr) begin
      state_nxt = F_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_RUN;
      sum_r   <= '0;
      pcnt_r  <= '0;
      span_r  <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_r[i] <= '0;
      end
      for (int i = 0; i < PEND; i++) begin
        pend_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      pcnt_r  <= pcnt_nxt;
      span_r  <= span_nxt;
      win_r   <= win_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/cclrn_back.sv
`default_nettype none
module cclrn_back
  import cclrn_pkg::*;
#(
  parameter int DATA_BITS = 16,
  parameter int SUM_W     = 36
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cclrn_cfg_t                 cfg,
  input  wire logic                       q_empty,
  input  wire logic [DATA_BITS+SUM_W:0]   q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [DATA_BITS-1:0]            out_data,
  output logic                            out_last
);

  localparam int SUM_HW = (SUM_W > 32) ? SUM_W - 32 : 1;
  localparam fact_tab_t FACTORS = make_factors();

  typedef enum logic [3:0] {
    B_IDLE, B_SLO, B_SHI, B_NORM, B_LOG, B_EXPN, B_POW, B_MAG, B_DONE
  } bstate_t;

  bstate_t              state_r;
  logic [DATA_BITS-1:0] smp_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 last_r, zero_r;
  logic [63:0]          plo_r, v_r;
  logic [31:0]          m_r, acc_r;
  logic [4:0]           e_r, it_r;
  logic [FRAC_BITS-1:0] frac_r, f24_r;
  logic signed [9:0]    ip_r;
  logic                 out_valid_r, out_last_r;
  logic [DATA_BITS-1:0] out_data_r;

  logic [SUM_HW+31:0]   sum_ext;
  logic [SUM_HW-1:0]    hi;
  logic                 hi_sat, neg, scale_sat;
  logic [31:0]          op_a, op_b, scale;
  logic [63:0]          prod;
  logic [71:0]          total;
  logic [32:0]          sqm;
  logic [DATA_BITS-1:0] mag, res;
  logic signed [5:0]    e_off;
  logic signed [29:0]   lg;
  logic signed [47:0]   e38;
  logic signed [10:0]   s, n;
  logic [63:0]          limit, r, rnd;
  logic                 out_free;

  assign sum_ext  = (SUM_HW + 32)'(sum_r);
  assign hi       = sum_ext[32 +: SUM_HW];
  assign hi_sat   = (SUM_HW > 24) && ((hi >> 24) != '0);
  assign neg      = smp_r[DATA_BITS-1];
  assign mag      = neg ? -smp_r : smp_r;
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  // shared 32x32 multiplier
  always_comb begin
    unique case (state_r)
      B_SLO: begin
        op_a = cfg.alpha_norm;
        op_b = sum_ext[31:0];
      end
      B_SHI: begin
        op_a = cfg.alpha_norm;
        op_b = 32'(hi);
      end
      B_LOG: begin
        op_a = m_r;
        op_b = m_r;
      end
      B_POW: begin
        op_a = acc_r;
        op_b = FACTORS[it_r];
      end
      B_MAG: begin
        op_a = acc_r;
        op_b = 32'(mag);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = 64'(op_a) * 64'(op_b);
  end

  // scale = k<<16 + floor(alpha*sum/2^24), saturated
  assign total     = (72'(prod) << 8) + 72'(plo_r >> 24) + (72'(cfg.bias_k) << 16);
  assign scale_sat = hi_sat || (total[71:32] != '0);
  assign scale     = scale_sat ? 32'hFFFF_FFFF : total[31:0];

  // log squaring step
  assign sqm = prod[63:31];

  // exponent -beta*log2(scale), Q.38
  assign e_off = $signed({1'b0, e_r}) - 6'sd24;
  assign lg    = {e_off, frac_r};
  assign e38   = -(48'(($signed({1'b0, cfg.beta_exponent})) * lg));

  // final shift, rounding and saturation
  always_comb begin
    s     = 11'(ip_r) - 11'sd30;
    n     = -s;
    limit = neg ? (64'd1 << (DATA_BITS - 1)) : ((64'd1 << (DATA_BITS - 1)) - 64'd1);
    rnd   = '0;
    if (zero_r) begin
      r = '0;
    end else if (!s[10]) begin
      r = (s >= 11'sd2) ? limit : (v_r << s[0]);
    end else if (n > 11'sd63) begin
      r = '0;
    end else begin
      rnd = (v_r >> (n[5:0] - 6'd1)) + 64'd1;
      r   = rnd >> 1;
    end
    if (r > limit) begin
      r = limit;
    end
    res = neg ? DATA_BITS'(-r) : DATA_BITS'(r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            smp_r   <= q_data[DATA_BITS-1:0];
            sum_r   <= q_data[DATA_BITS +: SUM_W];
            last_r  <= q_data[DATA_BITS+SUM_W];
            state_r <= B_SLO;
          end
        end
        B_SLO: begin
          plo_r   <= prod;
          state_r <= B_SHI;
        end
        B_SHI: begin
          m_r    <= scale;
          e_r    <= 5'd31;
          zero_r <= (scale == '0) || (smp_r == '0);
          state_r <= ((scale == '0) || (smp_r == '0)) ? B_DONE : B_NORM;
        end
        B_NORM: begin
          if (m_r[31]) begin
            it_r    <= '0;
            frac_r  <= '0;
            state_r <= B_LOG;
          end else begin
            m_r <= m_r << 1;
            e_r <= e_r - 1'b1;
          end
        end
        B_LOG: begin
          frac_r <= {frac_r[FRAC_BITS-2:0], sqm[32]};
          m_r    <= sqm[32] ? sqm[32:1] : sqm[31:0];
          it_r   <= it_r + 1'b1;
          if (it_r == 5'(FRAC_BITS - 1)) begin
            state_r <= B_EXPN;
          end
        end
        B_EXPN: begin
          ip_r    <= e38[47:38];
          f24_r   <= e38[37:14];
          acc_r   <= 32'h4000_0000;
          it_r    <= '0;
          state_r <= B_POW;
        end
        B_POW: begin
          if (f24_r[FRAC_BITS-1]) begin
            acc_r <= prod[61:30];
          end
          f24_r <= f24_r << 1;
          it_r  <= it_r + 1'b1;
          if (it_r == 5'(FRAC_BITS - 1)) begin
            state_r <= B_MAG;
          end
        end
        B_MAG: begin
          v_r     <= prod;
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_data_r  <= res;
            out_last_r  <= last_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire
